FILE: rtl/core/atsa_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the tilt/servo angle unit.
// Used by the controller, the datapath, the CORDIC unit and the top level.
// No dependencies.
package atsa_pkg;

  // Field widths on the stream ports
  localparam int SAMPLE_W    = 16;
  localparam int PITCH_W     = 15;
  localparam int ROLL_W      = 16;
  localparam int SERVO_W     = 15;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  // Iteration counts and counter width
  localparam int ITERS      = 23;
  localparam int SQRT_STEPS = 32;
  localparam int IDX_W      = 5;

  // CORDIC widths: operands, rotation registers, angle accumulator (2^-16 degree units)
  localparam int OPER_W   = 34;
  localparam int CORDIC_W = 36;
  localparam int ACC_W    = 26;

  localparam logic signed [ACC_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ACC_W-1:0] DEG180 = 26'sd11796480;

  // atan(2^-i) in 2^-16 degree units, rounded to nearest
  function automatic logic [ACC_W-1:0] atan_tab(input logic [IDX_W-1:0] idx);
    case (idx)
      5'd0:    return 26'd2949120;
      5'd1:    return 26'd1740967;
      5'd2:    return 26'd919879;
      5'd3:    return 26'd466945;
      5'd4:    return 26'd234379;
      5'd5:    return 26'd117304;
      5'd6:    return 26'd58666;
      5'd7:    return 26'd29335;
      5'd8:    return 26'd14668;
      5'd9:    return 26'd7334;
      5'd10:   return 26'd3667;
      5'd11:   return 26'd1833;
      5'd12:   return 26'd917;
      5'd13:   return 26'd458;
      5'd14:   return 26'd229;
      5'd15:   return 26'd115;
      5'd16:   return 26'd57;
      5'd17:   return 26'd29;
      5'd18:   return 26'd14;
      5'd19:   return 26'd7;
      5'd20:   return 26'd4;
      5'd21:   return 26'd2;
      5'd22:   return 26'd1;
      default: return 26'd0;
    endcase
  endfunction

  // Controller states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MULX  = 9'b000000010,
    ST_MULZ  = 9'b000000100,
    ST_ADD   = 9'b000001000,
    ST_SQRT  = 9'b000010000,
    ST_PINIT = 9'b000100000,
    ST_PITCH = 9'b001000000,
    ST_FINAL = 9'b010000000,
    ST_SPARE = 9'b100000000
  } atsa_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic             mul_z;
    logic             sum_first;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             cordic_init;
    logic             cordic_pitch;
    logic             cordic_step;
    logic [IDX_W-1:0] cordic_idx;
    logic             cap_roll;
    logic             finish;
  } atsa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
  } atsa_status_t;

endpackage

FILE: rtl/core/atsa_sqrt.sv
// Iterative floor square root of a 64-bit radicand, one result bit per step.
// Self-contained (no package items); driven by the datapath.
module atsa_sqrt (
  input  logic        clk,
  input  logic        init,
  input  logic        step,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  localparam int REM_W = 35;

  logic [63:0]      n_sh;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  // Bring down the next two radicand bits and form the trial subtrahend
  assign rem_sh = {rem[REM_W-3:0], n_sh[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  // Restoring digit recurrence
  always_ff @(posedge clk) begin
    if (init) begin
      n_sh <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (step) begin
      n_sh <= n_sh << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/atsa_cordic.sv
// Shared CORDIC vectoring unit for atan2(num, den), one iteration per step.
// Depends on atsa_pkg for widths, angle constants and the arctangent table.
module atsa_cordic (
  input  logic                                 clk,
  input  logic                                 init,
  input  logic                                 step,
  input  logic [atsa_pkg::IDX_W-1:0]           idx,
  input  logic signed [atsa_pkg::OPER_W-1:0]   num,
  input  logic signed [atsa_pkg::OPER_W-1:0]   den,
  output logic signed [atsa_pkg::ACC_W-1:0]    result
);

  localparam int CW = atsa_pkg::CORDIC_W;
  localparam int AW = atsa_pkg::ACC_W;

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [AW-1:0] acc;
  logic                 special;
  logic signed [AW-1:0] spec_val;

  logic signed [CW-1:0] num_e;
  logic signed [CW-1:0] den_e;
  logic signed [CW-1:0] x_sh;
  logic signed [CW-1:0] y_sh;
  logic signed [AW-1:0] tab;

  assign num_e = CW'(num);
  assign den_e = CW'(den);
  assign x_sh  = x >>> idx;
  assign y_sh  = y >>> idx;
  assign tab   = signed'(atsa_pkg::atan_tab(idx));

  // Pre-rotation into the right half plane, axis cases, then micro-rotations
  always_ff @(posedge clk) begin
    if (init) begin
      special <= (num == '0) || (den == '0);
      if (num == '0) begin
        spec_val <= (den >= 0) ? '0 : atsa_pkg::DEG180;
      end else begin
        spec_val <= (num > 0) ? atsa_pkg::DEG90 : -atsa_pkg::DEG90;
      end
      if (den > 0) begin
        x   <= den_e;
        y   <= num_e;
        acc <= '0;
      end else if (num > 0) begin
        x   <= num_e;
        y   <= -den_e;
        acc <= atsa_pkg::DEG90;
      end else begin
        x   <= -num_e;
        y   <= den_e;
        acc <= -atsa_pkg::DEG90;
      end
    end else if (step) begin
      if (y > 0) begin
        x   <= x + y_sh;
        y   <= y - x_sh;
        acc <= acc + tab;
      end else begin
        x   <= x - y_sh;
        y   <= y + x_sh;
        acc <= acc - tab;
      end
    end
  end

  // Axis cases bypass the rotation; otherwise clamp to +/-180 degrees
  always_comb begin
    if (special) begin
      result = spec_val;
    end else if (acc > atsa_pkg::DEG180) begin
      result = atsa_pkg::DEG180;
    end else if (acc < -atsa_pkg::DEG180) begin
      result = -atsa_pkg::DEG180;
    end else begin
      result = acc;
    end
  end

endmodule

FILE: rtl/core/atsa_datapath.sv
// Datapath: sample scaling, squaring, square root and CORDIC units, angle rounding,
// servo clamping, change strobes and the output register. Depends on atsa_pkg,
// atsa_sqrt and atsa_cordic; driven by atsa_ctrl commands.
module atsa_datapath #(
  parameter int SAMPLE_BITS     = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  atsa_pkg::atsa_cmd_t                    cmd,
  output atsa_pkg::atsa_status_t                 status,
  input  logic signed [atsa_pkg::SAMPLE_W-1:0]   accel_x,
  input  logic signed [atsa_pkg::SAMPLE_W-1:0]   accel_y,
  input  logic signed [atsa_pkg::SAMPLE_W-1:0]   accel_z,
  input  logic                                   m_tready,
  output logic                                   m_tvalid,
  output logic [atsa_pkg::OUT_TDATA_W-1:0]       m_tdata
);

  localparam int SCALE_SH  = 32 - SAMPLE_BITS;
  localparam int ANG_SHIFT = 16 - ANGLE_FRAC_BITS;
  localparam int ANGLE_W   = ANGLE_FRAC_BITS + 9;
  localparam int AW        = atsa_pkg::ACC_W;
  localparam int SUM_W     = AW + 1;
  localparam int OW        = atsa_pkg::OPER_W;

  localparam logic signed [SUM_W-1:0]   HALF        = SUM_W'(1) << (ANG_SHIFT - 1);
  localparam logic signed [ANGLE_W-1:0] RESET_ANGLE = ANGLE_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [ANGLE_W-1:0] SERVO_MAX   = ANGLE_W'(180 << ANGLE_FRAC_BITS);

  // Round 2^-16 degree accumulator to output units, halves upward
  function automatic logic signed [ANGLE_W-1:0] to_units(input logic signed [AW-1:0] a);
    logic signed [SUM_W-1:0] t;
    t = SUM_W'(a) + HALF;
    return ANGLE_W'(t >>> ANG_SHIFT);
  endfunction

  // Clamp an angle to the 0..180 degree servo range
  function automatic logic [ANGLE_W-1:0] to_servo(input logic signed [ANGLE_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > SERVO_MAX) begin
      return SERVO_MAX;
    end
    return v;
  endfunction

  logic signed [31:0]   sx;
  logic signed [31:0]   sy;
  logic signed [31:0]   sz;
  logic [31:0]          ax;
  logic [31:0]          az;
  logic [31:0]          mul_op;
  logic [63:0]          prod;
  logic [63:0]          sq_sum;
  logic [63:0]          radicand;
  logic [31:0]          root;
  logic signed [OW-1:0] c_num;
  logic signed [OW-1:0] c_den;
  logic signed [AW-1:0] c_res;
  logic signed [AW-1:0] roll_acc;
  logic signed [AW-1:0] pitch_acc;

  logic signed [ANGLE_W-1:0] pitch;
  logic signed [ANGLE_W-1:0] roll;
  logic [ANGLE_W-1:0]        pitch_sv;
  logic [ANGLE_W-1:0]        roll_sv;
  logic signed [ANGLE_W-1:0] previous_pitch;
  logic signed [ANGLE_W-1:0] previous_roll;
  logic                      pitch_write;
  logic                      yaw_write;

  // Sample capture: keep the low SAMPLE_BITS bits, scaled to a 32-bit word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= signed'({16'b0, accel_x} << SCALE_SH);
      sy <= signed'({16'b0, accel_y} << SCALE_SH);
      sz <= signed'({16'b0, accel_z} << SCALE_SH);
    end
  end

  assign ax = sx[31] ? (32'd0 - sx) : sx;
  assign az = sz[31] ? (32'd0 - sz) : sz;

  // Shared squarer, then x^2 + z^2
  assign mul_op   = cmd.mul_z ? az : ax;
  assign radicand = sq_sum + prod;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_op * mul_op;
    end
    if (cmd.sum_first) begin
      sq_sum <= prod;
    end
  end

  atsa_sqrt u_sqrt (
    .clk      (clk),
    .init     (cmd.sqrt_init),
    .step     (cmd.sqrt_step),
    .radicand (radicand),
    .root     (root)
  );

  // CORDIC operands: roll = atan2(-x, z), pitch = atan2(y, r)
  assign c_num = cmd.cordic_pitch ? OW'(sy) : -OW'(sx);
  assign c_den = cmd.cordic_pitch ? signed'({2'b00, root}) : OW'(sz);

  atsa_cordic u_cordic (
    .clk    (clk),
    .init   (cmd.cordic_init),
    .step   (cmd.cordic_step),
    .idx    (cmd.cordic_idx),
    .num    (c_num),
    .den    (c_den),
    .result (c_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_roll) begin
      roll_acc <= c_res;
    end
  end

  // Pitch limited to +/-90 degrees
  always_comb begin
    if (c_res > atsa_pkg::DEG90) begin
      pitch_acc = atsa_pkg::DEG90;
    end else if (c_res < -atsa_pkg::DEG90) begin
      pitch_acc = -atsa_pkg::DEG90;
    end else begin
      pitch_acc = c_res;
    end
  end

  assign pitch       = to_units(pitch_acc);
  assign roll        = to_units(roll_acc);
  assign pitch_sv    = to_servo(pitch);
  assign roll_sv     = to_servo(roll);
  assign pitch_write = (pitch != previous_pitch);
  assign yaw_write   = (roll != previous_roll);

  // Previous angles for change detection
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pitch <= RESET_ANGLE;
      previous_roll  <= RESET_ANGLE;
    end else if (cmd.finish) begin
      previous_pitch <= pitch;
      previous_roll  <= roll;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {1'b0, yaw_write, pitch_write,
                  atsa_pkg::SERVO_W'(roll_sv), atsa_pkg::SERVO_W'(pitch_sv),
                  atsa_pkg::ROLL_W'(roll), atsa_pkg::PITCH_W'(pitch)};
    end
  end

  assign status.out_free = !m_tvalid || m_tready;

`ifndef SYNTH
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result written while output register still held a transaction");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("output valid not raised after finish");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.cordic_init |-> !cmd.cordic_step)
    else $error("CORDIC init and step in the same cycle");
`endif

endmodule

FILE: rtl/core/atsa_ctrl.sv
// Controller state machine: sequences squaring, square root, roll and pitch CORDIC
// passes and the result write. Depends on atsa_pkg; commands the datapath.
module atsa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  atsa_pkg::atsa_status_t status,
  output atsa_pkg::atsa_cmd_t    cmd
);

  atsa_pkg::atsa_state_t          state;
  atsa_pkg::atsa_state_t          state_next;
  logic [atsa_pkg::IDX_W-1:0]     cnt;
  logic [atsa_pkg::IDX_W-1:0]     cnt_next;

  localparam logic [atsa_pkg::IDX_W-1:0] SQRT_LAST = atsa_pkg::IDX_W'(atsa_pkg::SQRT_STEPS - 1);
  localparam logic [atsa_pkg::IDX_W-1:0] CORD_LAST = atsa_pkg::IDX_W'(atsa_pkg::ITERS - 1);
  localparam logic [atsa_pkg::IDX_W-1:0] CORD_END  = atsa_pkg::IDX_W'(atsa_pkg::ITERS);

  assign in_ready = (state == atsa_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cordic_idx = cnt;
    unique case (state)
      atsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = atsa_pkg::ST_MULX;
        end
      end
      atsa_pkg::ST_MULX: begin
        cmd.mul_en = 1'b1;
        state_next = atsa_pkg::ST_MULZ;
      end
      atsa_pkg::ST_MULZ: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_z     = 1'b1;
        cmd.sum_first = 1'b1;
        state_next    = atsa_pkg::ST_ADD;
      end
      atsa_pkg::ST_ADD: begin
        // roll CORDIC overlaps the square root
        cmd.sqrt_init   = 1'b1;
        cmd.cordic_init = 1'b1;
        cnt_next        = '0;
        state_next      = atsa_pkg::ST_SQRT;
      end
      atsa_pkg::ST_SQRT: begin
        cmd.sqrt_step   = 1'b1;
        cmd.cordic_step = (cnt < CORD_END);
        cnt_next        = cnt + 1'b1;
        if (cnt == SQRT_LAST) begin
          state_next = atsa_pkg::ST_PINIT;
        end
      end
      atsa_pkg::ST_PINIT: begin
        cmd.cap_roll     = 1'b1;
        cmd.cordic_init  = 1'b1;
        cmd.cordic_pitch = 1'b1;
        cnt_next         = '0;
        state_next       = atsa_pkg::ST_PITCH;
      end
      atsa_pkg::ST_PITCH: begin
        cmd.cordic_pitch = 1'b1;
        cmd.cordic_step  = 1'b1;
        cnt_next         = cnt + 1'b1;
        if (cnt == CORD_LAST) begin
          state_next = atsa_pkg::ST_FINAL;
        end
      end
      atsa_pkg::ST_FINAL: begin
        cmd.cordic_pitch = 1'b1;
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = atsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = atsa_pkg::ST_IDLE;
      end
    endcase
  end

  // State and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atsa_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef SYNTH
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cmd.cordic_step |-> (cnt < CORD_END))
    else $error("CORDIC stepped past its last iteration");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after a transaction was accepted");
  a_idle_after_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> in_ready)
    else $error("controller not idle after result write");
`endif

endmodule

FILE: rtl/core/accel_tilt_servo_angles_unit.sv
// Accelerometer tilt to servo angles: pitch = atan2(y, sqrt(x^2+z^2)), roll = atan2(-x, z).
// One sample is processed at a time (s_tready only while idle); the throughput is set by the
// 32-step square root followed by the 23 pitch CORDIC iterations (roll overlaps).
// A finished result waits in the output register; a new sample is taken meanwhile.
// rst (synchronous) idles the controller, drops m_tvalid and sets both stored angles to 90 deg.
// Depends on atsa_pkg, atsa_ctrl and atsa_datapath.
module accel_tilt_servo_angles_unit #(
  parameter int SAMPLE_BITS     = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [atsa_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pitch_angle [14:0], roll_angle [30:15], pitch_servo [45:31], yaw_servo [60:46],
  // pitch_write [61], yaw_write [62], zero [63]
  output logic [atsa_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  atsa_pkg::atsa_cmd_t    cmd;
  atsa_pkg::atsa_status_t status;

  atsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  atsa_datapath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .accel_x  (s_tdata[15:0]),
    .accel_y  (s_tdata[31:16]),
    .accel_z  (s_tdata[47:32]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for accel_tilt_servo_angles_unit: drives accelerometer samples on
// the slave stream and checks pitch/roll, servo commands and write strobes against a predictor.
// Depends on atsa_pkg and the RTL of the tilt/servo angle unit.
module tb_top;

  // Angle constants in 2^-16 degree units, output step 2^-7 degree
  localparam longint ANG90      = 64'sd5898240;
  localparam longint ANG180     = 64'sd11796480;
  localparam int     FRAC_BITS  = 7;
  localparam int     OUT_SHIFT  = 16 - FRAC_BITS;
  localparam longint SERVO_TOP  = 180 << FRAC_BITS;
  localparam longint HOME_ANGLE = 90 << FRAC_BITS;
  localparam int     STALL_LIMIT = 4000;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     RANDOM_ITEMS = 1000;

  // atan(2^-i) in 2^-16 degree units
  localparam longint ATAN_STEP [0:22] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  typedef struct packed {
    logic                                zero_pad;
    logic                                yaw_write;
    logic                                pitch_write;
    logic [atsa_pkg::SERVO_W-1:0]        yaw_servo;
    logic [atsa_pkg::SERVO_W-1:0]        pitch_servo;
    logic signed [atsa_pkg::ROLL_W-1:0]  roll_angle;
    logic signed [atsa_pkg::PITCH_W-1:0] pitch_angle;
  } tilt_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [atsa_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [atsa_pkg::OUT_TDATA_W-1:0] m_tdata;

  // Predictor state: last angles before the servo clamp, in output units
  longint       last_pitch = HOME_ANGLE;
  longint       last_roll  = HOME_ANGLE;
  tilt_result_t angle_expect_q[$];

  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int samples_sent;
  int results_seen;
  int pitch_strobes;
  int yaw_strobes;
  int mismatch_count;
  int stall_cycles;

  accel_tilt_servo_angles_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC arctangent, result in 2^-16 degree units
  function automatic longint vector_angle(input longint num, input longint den);
    longint vx, vy, ang, nx;
    if (num == 0) return (den >= 0) ? 64'sd0 : ANG180;
    if (den == 0) return (num > 0) ? ANG90 : -ANG90;
    if (den > 0) begin
      vx = den; vy = num; ang = 0;
    end else if (num > 0) begin
      vx = num; vy = -den; ang = ANG90;
    end else begin
      vx = -num; vy = den; ang = -ANG90;
    end
    for (int i = 0; i < 23; i++) begin
      if (vy > 0) begin
        nx  = vx + (vy >>> i);
        vy  = vy - (vx >>> i);
        ang = ang + ATAN_STEP[i];
      end else begin
        nx  = vx - (vy >>> i);
        vy  = vy + (vx >>> i);
        ang = ang - ATAN_STEP[i];
      end
      vx = nx;
    end
    if (ang > ANG180) ang = ANG180;
    if (ang < -ANG180) ang = -ANG180;
    return ang;
  endfunction

  // Round to output step, halves upward
  function automatic longint to_out_step(input longint ang);
    longint bias;
    bias = 64'sd16777216;
    return ((ang + bias + (64'sd1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT) - (bias >>> OUT_SHIFT);
  endfunction

  function automatic logic [atsa_pkg::SERVO_W-1:0] servo_cmd(input longint ang);
    longint lim;
    lim = ang;
    if (lim < 0) lim = 0;
    if (lim > SERVO_TOP) lim = SERVO_TOP;
    return lim[atsa_pkg::SERVO_W-1:0];
  endfunction

  // Expected result for one sample; advances the stored angles
  function automatic tilt_result_t predict_angles(
      input logic signed [atsa_pkg::SAMPLE_W-1:0] ax,
      input logic signed [atsa_pkg::SAMPLE_W-1:0] ay,
      input logic signed [atsa_pkg::SAMPLE_W-1:0] az);
    longint          sx, sy, sz, radial, pa, ra;
    longint unsigned mx, mz;
    tilt_result_t    res;
    sx = longint'(ax) * 65536;
    sy = longint'(ay) * 65536;
    sz = longint'(az) * 65536;
    mx = (sx < 0) ? -sx : sx;
    mz = (sz < 0) ? -sz : sz;
    radial = longint'(floor_root(mx * mx + mz * mz));
    pa = vector_angle(sy, radial);
    if (pa > ANG90) pa = ANG90;
    if (pa < -ANG90) pa = -ANG90;
    ra = vector_angle(-sx, sz);
    pa = to_out_step(pa);
    ra = to_out_step(ra);
    res.zero_pad    = 1'b0;
    res.pitch_angle = pa[atsa_pkg::PITCH_W-1:0];
    res.roll_angle  = ra[atsa_pkg::ROLL_W-1:0];
    res.pitch_servo = servo_cmd(pa);
    res.yaw_servo   = servo_cmd(ra);
    res.pitch_write = (pa != last_pitch);
    res.yaw_write   = (ra != last_roll);
    last_pitch = pa;
    last_roll  = ra;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transaction, check each output transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tilt_result_t want;
    tilt_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        angle_expect_q.push_back(predict_angles(s_tdata[15:0], s_tdata[31:16],
                                                s_tdata[47:32]));
        samples_sent++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        pitch_strobes += got.pitch_write;
        yaw_strobes   += got.yaw_write;
        if (angle_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result tdata=%h", $time, m_tdata);
        end else begin
          want = angle_expect_q.pop_front();
          if (got.pitch_angle !== want.pitch_angle || got.roll_angle !== want.roll_angle ||
              got.pitch_servo !== want.pitch_servo || got.yaw_servo !== want.yaw_servo ||
              got.pitch_write !== want.pitch_write || got.yaw_write !== want.yaw_write ||
              got.zero_pad !== want.zero_pad) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] result %0d wrong", $time, results_seen);
              $display("  exp pitch=%0d roll=%0d psrv=%0d ysrv=%0d pw=%b yw=%b pad=%b",
                       want.pitch_angle, want.roll_angle, want.pitch_servo, want.yaw_servo,
                       want.pitch_write, want.yaw_write, want.zero_pad);
              $display("  got pitch=%0d roll=%0d psrv=%0d ysrv=%0d pw=%b yw=%b pad=%b",
                       got.pitch_angle, got.roll_angle, got.pitch_servo, got.yaw_servo,
                       got.pitch_write, got.yaw_write, got.zero_pad);
            end
          end
        end
      end
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    m_tready <= !sink_idle_on || ($urandom_range(99) >= 35);
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One sample transaction; tvalid stays high after acceptance unless a gap follows
  task automatic send_sample(input logic signed [atsa_pkg::SAMPLE_W-1:0] ax,
                             input logic signed [atsa_pkg::SAMPLE_W-1:0] ay,
                             input logic signed [atsa_pkg::SAMPLE_W-1:0] az);
    while (src_idle_on && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {az, ay, ax};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Right after reset both angles sit at 90 deg: straight-up y keeps pitch, no pitch strobe
  task automatic test_reset_state();
    send_sample(0, 1000, 0);
  endtask

  // Zero operands in each atan2 and the exact quadrant angles
  task automatic test_special_cases();
    send_sample(0, 0, 0);
    send_sample(0, 0, 5000);
    send_sample(0, 0, -5000);
    send_sample(-4000, 0, 0);
    send_sample(4000, 0, 0);
    send_sample(0, -1000, 0);
    send_sample(3000, 0, 4000);
    send_sample(-1, 0, -1);
  endtask

  task automatic test_extremes();
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, 32767, 0);
    send_sample(32767, -32768, -32768);
    send_sample(0, 32767, -32768);
    send_sample(-32768, 0, 32767);
    send_sample(1, -1, 1);
    send_sample(-1, 1, -1);
  endtask

  // Same sample twice: second one raises no strobe
  task automatic test_repeat_sample();
    send_sample(12345, -2222, 3333);
    send_sample(12345, -2222, 3333);
    send_sample(0, 0, 0);
    send_sample(0, 0, 0);
  endtask

  function automatic logic signed [atsa_pkg::SAMPLE_W-1:0] pick_corner();
    case ($urandom_range(5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic logic signed [atsa_pkg::SAMPLE_W-1:0] pick_small();
    return atsa_pkg::SAMPLE_W'($urandom_range(16) - 8);
  endfunction

  task automatic test_random_samples();
    logic signed [atsa_pkg::SAMPLE_W-1:0] rx, ry, rz;
    rx = 0; ry = 0; rz = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // quiet stretch on both sides
      src_idle_on  = !(n >= 400 && n < 600);
      sink_idle_on = src_idle_on;
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          rx = atsa_pkg::SAMPLE_W'($urandom);
          ry = atsa_pkg::SAMPLE_W'($urandom);
          rz = atsa_pkg::SAMPLE_W'($urandom);
        end
        4, 5: begin
          rx = pick_small(); ry = pick_small(); rz = pick_small();
        end
        6: ; // repeat the previous sample
        7: begin
          rx = $urandom_range(1) ? '0 : atsa_pkg::SAMPLE_W'($urandom);
          ry = $urandom_range(1) ? '0 : atsa_pkg::SAMPLE_W'($urandom);
          rz = $urandom_range(1) ? '0 : atsa_pkg::SAMPLE_W'($urandom);
        end
        8: begin
          // near-level board: roll and pitch close to the servo clamp edges
          rx = atsa_pkg::SAMPLE_W'($urandom_range(400) - 200);
          ry = atsa_pkg::SAMPLE_W'($urandom_range(400) - 200);
          rz = $urandom_range(1) ? atsa_pkg::SAMPLE_W'(16384 + $urandom_range(2000))
                                 : atsa_pkg::SAMPLE_W'(-16384 - $urandom_range(2000));
        end
        default: begin
          rx = pick_corner(); ry = pick_corner(); rz = pick_corner();
        end
      endcase
      send_sample(rx, ry, rz);
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_special_cases();
    test_extremes();
    test_repeat_sample();
    test_random_samples();
    s_tvalid <= 1'b0;
    while (angle_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (angle_expect_q.size() != 0) mismatch_count++;
    $display("Checked %0d tilt results from %0d samples (%0d mismatches).",
             results_seen, samples_sent, mismatch_count);
    $display("Pitch strobes raised %0d times, yaw strobes %0d times.",
             pitch_strobes, yaw_strobes);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/atsa_pkg.sv
rtl/core/atsa_sqrt.sv
rtl/core/atsa_cordic.sv
rtl/core/atsa_datapath.sv
rtl/core/atsa_ctrl.sv
rtl/core/accel_tilt_servo_angles_unit.sv
tb/sv/tb_top.sv
